### sv/assert_macros.svh
// Assertion macros for the filter RTL, included by the filter core.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define TCOF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define TCOF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

### sv/tcof_pkg.sv
// Types, constants and saturating helpers for the clock offset filter.
// No dependencies; every module in the project imports this package.
`timescale 1ns / 1ps

package tcof_pkg;

    localparam int FRACTION_BITS    = 16;
    localparam int GAIN_TABLE_DEPTH = 256;
    localparam int TBL_IDX_W        = $clog2(GAIN_TABLE_DEPTH);
    localparam int TBL_ADDR_W       = TBL_IDX_W + 1;
    localparam int X_LIMIT_BITS     = 51;
    localparam int TABLE_Q          = 60;
    localparam int CFG_ADDR_W       = 5;

    localparam logic [16:0] GAIN_ONE = 17'd65536;

    localparam logic signed [63:0] S64_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN     = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] Q_BOUND     = S64_MAX >>> FRACTION_BITS;
    localparam logic signed [63:0] Q_BOUND_NEG = ~Q_BOUND;

    // Operation codes carried on the input tuser.
    localparam logic [2:0] OP_FWD_SET    = 3'd0;
    localparam logic [2:0] OP_FWD_SAMPLE = 3'd1;
    localparam logic [2:0] OP_REV_SET    = 3'd2;
    localparam logic [2:0] OP_REV_SAMPLE = 3'd3;
    localparam logic [2:0] OP_REBASE     = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_STEP_GAIN  = 3'd0;
    localparam logic [2:0] REG_NEG_LIMIT  = 3'd1;
    localparam logic [2:0] REG_FAST_TAU   = 3'd2;
    localparam logic [2:0] REG_SLOW_TAU   = 3'd3;
    localparam logic [2:0] REG_BAND_FRAC  = 3'd4;

    typedef struct packed {
        logic [15:0] step_gain;
        logic [31:0] negative_limit_ns;
        logic [31:0] fast_inverse_tau;
        logic [31:0] slow_inverse_tau;
        logic [15:0] band_half_fraction;
    } cfg_t;

    typedef logic [16:0] gain_tbl_t [0:GAIN_TABLE_DEPTH];

    // Shift-and-subtract division, used only while the gain table is built.
    function automatic logic [63:0] div_u64(input logic [63:0] num,
                                            input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // 1 - exp(-x) in Q0.16 at steps of 8/GAIN_TABLE_DEPTH, built from a
    // Q60 power series of exp(-8/GAIN_TABLE_DEPTH) raised step by step.
    function automatic gain_tbl_t build_gain_table();
        gain_tbl_t    tbl;
        logic [63:0]  term;
        logic [63:0]  pos;
        logic [63:0]  neg;
        logic [63:0]  r;
        logic [63:0]  p;
        logic [127:0] wide;
        term = 64'd1 << TABLE_Q;
        pos  = term;
        neg  = '0;
        for (int n = 1; n <= 40; n++) begin
            term = div_u64(term * 64'd8, 64'(GAIN_TABLE_DEPTH) * 64'(n));
            if ((n & 1) != 0) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        r = pos - neg;
        p = 64'd1 << TABLE_Q;
        for (int k = 0; k <= GAIN_TABLE_DEPTH; k++) begin
            tbl[k] = GAIN_ONE -
                17'((p + (64'd1 << (TABLE_Q - 17))) >> (TABLE_Q - 16));
            wide = {64'd0, p} * {64'd0, r};
            p    = wide[TABLE_Q +: 64];
        end
        return tbl;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    // Nanoseconds to fixed point, saturating.
    function automatic logic signed [63:0] to_q(input logic signed [63:0] v);
        if (v > Q_BOUND) begin
            return S64_MAX;
        end else if (v < Q_BOUND_NEG) begin
            return S64_MIN;
        end
        return v <<< FRACTION_BITS;
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] a);
        if (a < 0) begin
            return 64'(-a);
        end
        return 64'(a);
    endfunction

endpackage

### sv/tcof_cfg.sv
// Configuration register file on an APB-style port.
// Depends on tcof_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module tcof_cfg
    import tcof_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_gain          <= 16'd328;
            cfg_reg.negative_limit_ns  <= 32'd300000;
            cfg_reg.fast_inverse_tau   <= 32'd562950;
            cfg_reg.slow_inverse_tau   <= 32'd28147;
            cfg_reg.band_half_fraction <= 16'd16384;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_STEP_GAIN: cfg_reg.step_gain          <= pwdata[15:0];
                REG_NEG_LIMIT: cfg_reg.negative_limit_ns  <= pwdata;
                REG_FAST_TAU:  cfg_reg.fast_inverse_tau   <= pwdata;
                REG_SLOW_TAU:  cfg_reg.slow_inverse_tau   <= pwdata;
                REG_BAND_FRAC: cfg_reg.band_half_fraction <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STEP_GAIN: prdata = {16'd0, cfg_reg.step_gain};
            REG_NEG_LIMIT: prdata = cfg_reg.negative_limit_ns;
            REG_FAST_TAU:  prdata = cfg_reg.fast_inverse_tau;
            REG_SLOW_TAU:  prdata = cfg_reg.slow_inverse_tau;
            REG_BAND_FRAC: prdata = {16'd0, cfg_reg.band_half_fraction};
            default:       prdata = '0;
        endcase
    end

endmodule

### sv/tcof_mul.sv
// Shared 64 x 32 multiplier built from one 32 x 32 product used twice.
// Depends on tcof_pkg only through the common import.
`timescale 1ns / 1ps

module tcof_mul
    import tcof_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [31:0] b,
    output logic        busy,
    output logic        done,
    output logic [95:0] prod
);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_LO   = 2'd1;
    localparam logic [1:0] P_HI   = 2'd2;
    localparam logic [1:0] P_ACC  = 2'd3;

    logic [1:0]  phase_reg;
    logic [31:0] a_lo_reg;
    logic [31:0] a_hi_reg;
    logic [31:0] b_reg;
    logic [63:0] pp_reg;
    logic [95:0] acc_reg;
    logic        done_reg;
    logic [31:0] mul_in;
    logic [63:0] mul_out;

    // The single multiplier sees the low half first, then the high half.
    assign mul_in  = (phase_reg == P_LO) ? a_lo_reg : a_hi_reg;
    assign mul_out = 64'(mul_in) * 64'(b_reg);

    assign busy = (phase_reg != P_IDLE);
    assign done = done_reg;
    assign prod = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                P_IDLE: begin
                    if (start) begin
                        phase_reg <= P_LO;
                    end
                end
                P_LO:  phase_reg <= P_HI;
                P_HI:  phase_reg <= P_ACC;
                P_ACC: begin
                    phase_reg <= P_IDLE;
                    done_reg  <= 1'b1;
                end
                default: phase_reg <= P_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == P_IDLE && start) begin
            a_lo_reg <= a[31:0];
            a_hi_reg <= a[63:32];
            b_reg    <= b;
        end
        if (phase_reg == P_LO) begin
            pp_reg <= mul_out;
        end
        if (phase_reg == P_HI) begin
            acc_reg <= {32'd0, pp_reg};
            pp_reg  <= mul_out;
        end
        if (phase_reg == P_ACC) begin
            acc_reg <= acc_reg + {pp_reg, 32'd0};
        end
    end

endmodule

### sv/tcof_gain_rom.sv
// Constant table of 1 - exp(-x) with a registered read port.
// Depends on tcof_pkg for the table builder and its sizes.
`timescale 1ns / 1ps

module tcof_gain_rom
    import tcof_pkg::*;
(
    input  logic                  aclk,
    input  logic [TBL_ADDR_W-1:0] addr,
    output logic [16:0]           data
);

    localparam gain_tbl_t GAIN_TABLE = build_gain_table();

    logic [16:0] data_reg;

    assign data = data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= GAIN_TABLE[addr];
    end

endmodule

### sv/two_way_clock_offset_filter_core.sv
// One item is worked at a time: s_tready is high only while the sequencer is idle, and it
// returns in the cycle after the result is loaded. The shared multiplier sets the latency,
// and a sample needs up to 8 of its products; rebase, clear and unused ops need none.
// Reset (aresetn, synchronous, active low) clears all estimates, times, seen flags and
// the base offset and loads the register defaults. A result may wait at the output.
`timescale 1ns / 1ps

module two_way_clock_offset_filter_core
    import tcof_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [127:0]          s_tdata,  // time_now[62:0], sample_value[126:63]
    input  logic [2:0]            s_tuser,  // op[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [191:0]          m_tdata,  // estimate, fwd_estimate, rev_estimate
    output logic [0:0]            m_tuser,  // both_seen
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    `include "assert_macros.svh"

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_PREP      = 5'd1;
    localparam logic [4:0] S_APPLY     = 5'd2;
    localparam logic [4:0] S_REBASE    = 5'd3;
    localparam logic [4:0] S_PULL1     = 5'd4;
    localparam logic [4:0] S_GAIN_MUL  = 5'd5;
    localparam logic [4:0] S_GAIN_TA   = 5'd6;
    localparam logic [4:0] S_GAIN_TB   = 5'd7;
    localparam logic [4:0] S_GAIN_IMUL = 5'd8;
    localparam logic [4:0] S_PULL2_GO  = 5'd9;
    localparam logic [4:0] S_PULL2     = 5'd10;
    localparam logic [4:0] S_EST_DONE  = 5'd11;
    localparam logic [4:0] S_COMB_PREP = 5'd12;
    localparam logic [4:0] S_HB        = 5'd13;
    localparam logic [4:0] S_COMB_GO   = 5'd14;
    localparam logic [4:0] S_COMB_MUL  = 5'd15;
    localparam logic [4:0] S_CLAMP     = 5'd16;
    localparam logic [4:0] S_OUT       = 5'd17;

    cfg_t cfg;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    // Item being worked.
    logic [2:0]         op_reg;
    logic [62:0]        now_reg;
    logic signed [63:0] sv_reg;
    logic signed [63:0] s_reg;
    logic [62:0]        dt_reg;
    logic               prev_seen_reg;
    logic signed [63:0] est_reg;
    logic [16:0]        gain_reg;
    logic               gsel_reg;
    logic [TBL_IDX_W-1:0] idx_reg;
    logic [15:0]        frac_reg;
    logic [16:0]        tbl_a_reg;
    logic signed [63:0] avg_reg;
    logic signed [63:0] hb_reg;
    logic signed [63:0] lo_reg;
    logic signed [63:0] hi_reg;
    logic               down_reg;

    // Filter state.
    logic signed [63:0] base_reg;
    logic signed [63:0] fwd_reg;
    logic signed [63:0] rev_reg;
    logic signed [63:0] comb_reg;
    logic [62:0]        fwd_last_reg;
    logic [62:0]        rev_last_reg;
    logic               fwd_seen_reg;
    logic               rev_seen_reg;

    logic               m_tvalid_reg;
    logic [191:0]       m_tdata_reg;
    logic               m_tuser_reg;

    logic               mul_start;
    logic [63:0]        mul_a;
    logic [31:0]        mul_b;
    logic               mul_busy;
    logic               mul_done;
    logic [95:0]        mul_prod;

    logic [TBL_ADDR_W-1:0] rom_addr;
    logic [16:0]        rom_data;

    logic               is_rev;
    logic               is_sample;
    logic signed [63:0] cur_est;
    logic [62:0]        cur_last;
    logic               cur_seen;
    logic signed [63:0] base_adj;
    logic [63:0]        lim;
    logic signed [63:0] pull_src;
    logic [63:0]        pull_d;
    logic [63:0]        pull_amt;
    logic               do_pull;
    logic               x_over;
    logic [TBL_IDX_W-1:0] idx_w;
    logic [15:0]        frac_w;
    logic signed [63:0] sum_fr;
    logic signed [63:0] diff_fr;
    logic [63:0]        step_amt;
    logic               out_free;

    tcof_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcof_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    tcof_gain_rom u_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign is_rev    = (op_reg == OP_REV_SET) || (op_reg == OP_REV_SAMPLE);
    assign is_sample = (op_reg == OP_FWD_SAMPLE) || (op_reg == OP_REV_SAMPLE);
    assign cur_est   = is_rev ? rev_reg : fwd_reg;
    assign cur_last  = is_rev ? rev_last_reg : fwd_last_reg;
    assign cur_seen  = is_rev ? rev_seen_reg : fwd_seen_reg;
    assign base_adj  = is_rev ? sat_add(sv_reg, base_reg) : sat_sub(sv_reg, base_reg);
    assign lim       = 64'(cfg.negative_limit_ns) << FRACTION_BITS;
    // The first pull starts from the stored estimate, the second from the working copy.
    assign pull_src  = (state_reg == S_APPLY) ? cur_est : est_reg;
    assign pull_d    = 64'(s_reg - pull_src);
    assign pull_amt  = (pull_d > lim) ? lim : pull_d;
    assign do_pull   = is_sample && prev_seen_reg && !(s_reg < cur_est);
    assign step_amt  = mul_prod[79:16];

    // Fields of x = dt * inverse_tau in Q48: saturation, table index, interpolation.
    assign x_over = |mul_prod[95:X_LIMIT_BITS];
    assign idx_w  = mul_prod[X_LIMIT_BITS-1 -: TBL_IDX_W];
    assign frac_w = mul_prod[X_LIMIT_BITS-TBL_IDX_W-1 -: 16];

    assign sum_fr  = sat_add(fwd_reg, rev_reg);
    assign diff_fr = sat_sub(fwd_reg, rev_reg);

    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        rom_addr   = TBL_ADDR_W'(idx_reg) + 1'b1;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                unique case (op_reg) inside
                    OP_FWD_SET, OP_FWD_SAMPLE, OP_REV_SET, OP_REV_SAMPLE:
                        state_next = S_APPLY;
                    OP_REBASE: state_next = S_REBASE;
                    default:   state_next = S_OUT;
                endcase
            end
            S_APPLY: begin
                if (do_pull) begin
                    mul_start  = 1'b1;
                    mul_a      = pull_amt;
                    mul_b      = 32'(cfg.step_gain);
                    state_next = S_PULL1;
                end else begin
                    state_next = S_EST_DONE;
                end
            end
            S_REBASE: state_next = S_OUT;
            S_PULL1: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = 64'(dt_reg);
                    mul_b      = cfg.fast_inverse_tau;
                    state_next = S_GAIN_MUL;
                end
            end
            S_GAIN_MUL: begin
                rom_addr = TBL_ADDR_W'(idx_w);
                if (mul_done) begin
                    if (x_over) begin
                        state_next = gsel_reg ? S_COMB_GO : S_PULL2_GO;
                    end else begin
                        state_next = S_GAIN_TA;
                    end
                end
            end
            S_GAIN_TA: state_next = S_GAIN_TB;
            S_GAIN_TB: begin
                mul_start  = 1'b1;
                mul_a      = 64'(rom_data - tbl_a_reg);
                mul_b      = 32'(frac_reg);
                state_next = S_GAIN_IMUL;
            end
            S_GAIN_IMUL: begin
                if (mul_done) begin
                    state_next = gsel_reg ? S_COMB_GO : S_PULL2_GO;
                end
            end
            S_PULL2_GO: begin
                mul_start  = 1'b1;
                mul_a      = pull_amt;
                mul_b      = 32'(gain_reg);
                state_next = S_PULL2;
            end
            S_PULL2: begin
                if (mul_done) begin
                    state_next = S_EST_DONE;
                end
            end
            S_EST_DONE: state_next = S_COMB_PREP;
            S_COMB_PREP: begin
                mul_start  = 1'b1;
                mul_a      = magnitude(sum_fr);
                mul_b      = 32'(cfg.band_half_fraction);
                state_next = S_HB;
            end
            S_HB: begin
                if (mul_done) begin
                    if (prev_seen_reg) begin
                        mul_start  = 1'b1;
                        mul_a      = 64'(dt_reg);
                        mul_b      = cfg.slow_inverse_tau;
                        state_next = S_GAIN_MUL;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_COMB_GO: begin
                mul_start  = 1'b1;
                mul_a      = (comb_reg >= avg_reg) ? 64'(comb_reg - avg_reg)
                                                   : 64'(avg_reg - comb_reg);
                mul_b      = 32'(gain_reg);
                state_next = S_COMB_MUL;
            end
            S_COMB_MUL: begin
                if (mul_done) begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP: state_next = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            base_reg     <= '0;
            fwd_reg      <= '0;
            rev_reg      <= '0;
            comb_reg     <= '0;
            fwd_last_reg <= '0;
            rev_last_reg <= '0;
            fwd_seen_reg <= 1'b0;
            rev_seen_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_PREP: begin
                    if (op_reg == OP_CLEAR) begin
                        base_reg     <= '0;
                        fwd_reg      <= '0;
                        rev_reg      <= '0;
                        comb_reg     <= '0;
                        fwd_last_reg <= '0;
                        rev_last_reg <= '0;
                        fwd_seen_reg <= 1'b0;
                        rev_seen_reg <= 1'b0;
                    end
                end
                S_REBASE: begin
                    // s_reg holds the base change in fixed point here.
                    fwd_reg      <= sat_sub(fwd_reg, s_reg);
                    rev_reg      <= sat_add(rev_reg, s_reg);
                    comb_reg     <= sat_sub(comb_reg, s_reg);
                    base_reg     <= sv_reg;
                    fwd_last_reg <= '0;
                    rev_last_reg <= '0;
                    fwd_seen_reg <= 1'b0;
                    rev_seen_reg <= 1'b0;
                end
                S_EST_DONE: begin
                    if (is_rev) begin
                        rev_reg      <= est_reg;
                        rev_last_reg <= now_reg;
                        rev_seen_reg <= 1'b1;
                    end else begin
                        fwd_reg      <= est_reg;
                        fwd_last_reg <= now_reg;
                        fwd_seen_reg <= 1'b1;
                    end
                end
                S_HB: begin
                    if (mul_done && !prev_seen_reg) begin
                        comb_reg <= avg_reg;
                    end
                end
                S_COMB_MUL: begin
                    if (mul_done) begin
                        comb_reg <= down_reg ? comb_reg - step_amt : comb_reg + step_amt;
                    end
                end
                S_CLAMP: begin
                    if (comb_reg < lo_reg) begin
                        comb_reg <= lo_reg;
                    end else if (comb_reg > hi_reg) begin
                        comb_reg <= hi_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg  <= s_tuser;
            now_reg <= s_tdata[62:0];
            sv_reg  <= s_tdata[126:63];
        end
        if (state_reg == S_PREP) begin
            s_reg         <= to_q(base_adj);
            dt_reg        <= (cur_seen && now_reg > cur_last) ? now_reg - cur_last : '0;
            prev_seen_reg <= cur_seen;
        end
        if (state_reg == S_APPLY) begin
            est_reg <= do_pull ? cur_est : s_reg;
        end
        if ((state_reg == S_PULL1 || state_reg == S_PULL2) && mul_done) begin
            est_reg <= est_reg + step_amt;
        end
        if (state_reg == S_PULL1 && mul_done) begin
            gsel_reg <= 1'b0;
        end
        if (state_reg == S_HB && mul_done) begin
            hb_reg   <= $signed(step_amt);
            gsel_reg <= 1'b1;
        end
        if (state_reg == S_GAIN_MUL && mul_done) begin
            gain_reg <= GAIN_ONE;
            idx_reg  <= idx_w;
            frac_reg <= frac_w;
        end
        if (state_reg == S_GAIN_TA) begin
            tbl_a_reg <= rom_data;
        end
        if (state_reg == S_GAIN_IMUL && mul_done) begin
            gain_reg <= tbl_a_reg + mul_prod[32:16];
        end
        if (state_reg == S_COMB_PREP) begin
            avg_reg <= diff_fr >>> 1;
        end
        if (state_reg == S_COMB_GO) begin
            down_reg <= (comb_reg >= avg_reg);
            lo_reg   <= sat_sub(avg_reg, hb_reg);
            hi_reg   <= sat_add(avg_reg, hb_reg);
        end
        if (state_reg == S_OUT && out_free) begin
            m_tdata_reg <= {rev_reg, fwd_reg, comb_reg};
            m_tuser_reg <= fwd_seen_reg && rev_seen_reg;
        end
    end

    `TCOF_ASSERT_NEXT(a_accept_to_prep, s_tvalid && s_tready, state_reg == S_PREP, "transfer accepted but sequencer did not start")
    `TCOF_ASSERT(a_mul_start_idle, !(mul_start && mul_busy), "multiplier started while busy")
    `TCOF_ASSERT_NEXT(a_clamp_band, state_reg == S_CLAMP, comb_reg >= lo_reg && comb_reg <= hi_reg, "combined estimate outside band")

endmodule
